### hw/rtl/assert_macros.svh
// Concurrent assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// General property, checked while out of reset.
`define XILD_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
// Same-cycle implication, checked while out of reset.
`define XILD_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`else
`define XILD_ASSERT(lbl, ck, rn, prop, msg)
`define XILD_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`endif
`endif

### hw/rtl/xild_pkg.sv
// Types, opcode constants and opcode tables for the instruction length decoder.
`default_nettype none
package xild_pkg;

    localparam int WORD_W     = 64;
    localparam int WIN_IN_W   = 2 * WORD_W;
    localparam int LEN_W      = 6;
    localparam int OUT_LEN_W  = 5;
    localparam int PICK_BYTES = 5;

    localparam logic [7:0] OP_ESC      = 8'h0F;
    localparam logic [7:0] OP_ESC_38   = 8'h38;
    localparam logic [7:0] OP_ESC_3A   = 8'h3A;
    localparam logic [7:0] PFX_OPSZ    = 8'h66;
    localparam logic [7:0] PFX_ADSZ    = 8'h67;
    localparam logic [7:0] OP_ENTER    = 8'hC8;
    localparam logic [7:0] OP_JMPF     = 8'hEA;
    localparam logic [7:0] OP_CALLF    = 8'h9A;
    localparam logic [7:0] OP_GRP3_B   = 8'hF6;
    localparam logic [7:0] OP_GRP3_V   = 8'hF7;
    localparam logic [7:0] OP_RETN_IMM = 8'hC2;
    localparam logic [7:0] OP_RETF_IMM = 8'hCA;
    localparam logic [3:0] REX_NIB     = 4'h4;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [1:0] op_len;     // opcode bytes, 1 to 3
        logic       has_modrm;
        logic [3:0] imm;        // immediate bytes
    } opdec_t;

    function automatic byte_t byte_at(input logic [WIN_IN_W-1:0] w, input logic [4:0] idx);
        byte_t b;
        b = 8'h00;
        if (!idx[4])
        begin
            b = w[{idx[3:0], 3'b000} +: 8];
        end
        return b;
    endfunction

    function automatic logic is_legacy(input byte_t b);
        logic hit;
        case (b)
            8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65,
            PFX_OPSZ, PFX_ADSZ: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic one_modrm(input byte_t b);
        logic hit;
        case (b)
            8'h62, 8'h63, 8'h69, 8'h6B, 8'hC0, 8'hC1, 8'hC4, 8'hC5, 8'hC6,
            8'hC7, 8'hD0, 8'hD1, 8'hD2, 8'hD3, OP_GRP3_B, OP_GRP3_V, 8'hFE,
            8'hFF: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic one_imm8(input byte_t b);
        logic hit;
        case (b)
            8'h6A, 8'h6B, 8'h80, 8'h82, 8'h83, 8'hA8, 8'hC0, 8'hC1, 8'hC6,
            8'hCD, 8'hD4, 8'hD5, 8'hEB: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic one_imm32(input byte_t b);
        logic hit;
        case (b)
            8'h68, 8'h69, 8'h81, 8'hA9, 8'hC7, 8'hE8, 8'hE9: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic two_modrm(input byte_t b);
        logic hit;
        case (b)
            8'h0D, 8'hA3, 8'hA4, 8'hA5, 8'hAB, 8'hAC, 8'hAD, 8'hAE,
            8'hAF: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/xild_in_if.sv
// Window channel: one instruction window per beat.
`default_nettype none
interface xild_in_if;
    logic                       valid;
    logic                       ready;
    logic [xild_pkg::WORD_W-1:0] window_low;
    logic [xild_pkg::WORD_W-1:0] window_high;

    modport source (output valid, output window_low, output window_high, input ready);
    modport sink   (input valid, input window_low, input window_high, output ready);
endinterface
`default_nettype wire

### hw/rtl/xild_out_if.sv
// Result channel: one decoded length per beat.
`default_nettype none
interface xild_out_if;
    logic                           valid;
    logic                           ready;
    logic [xild_pkg::OUT_LEN_W-1:0] length;
    logic                           beyond_window;

    modport source (output valid, output length, output beyond_window, input ready);
    modport sink   (input valid, input length, input beyond_window, output ready);
endinterface
`default_nettype wire

### hw/rtl/xild_opdec.sv
// Opcode classifier: opcode length, immediate size and ModR/M presence.
`default_nettype none
module xild_opdec (
    input  wire xild_pkg::byte_t  op0,
    input  wire xild_pkg::byte_t  op1,
    input  wire logic             opsz,
    input  wire logic             adsz,
    input  wire logic             rexw,
    output xild_pkg::opdec_t      dec
);

    logic [3:0] r0;
    logic [3:0] k0;
    logic [3:0] r1;
    logic [3:0] k1;
    logic [3:0] full_imm;

    assign r0 = op0[7:4];
    assign k0 = op0[3:0];
    assign r1 = op1[7:4];
    assign k1 = op1[3:0];
    assign full_imm = rexw ? 4'd8 : (opsz ? 4'd2 : 4'd4);

    always_comb
    begin
        dec = '0;
        if (op0 == xild_pkg::OP_ESC)
        begin
            if (op1 == xild_pkg::OP_ESC_38 || op1 == xild_pkg::OP_ESC_3A)
            begin
                dec.op_len    = 2'd3;
                dec.has_modrm = 1'b1;
                dec.imm       = (op1 == xild_pkg::OP_ESC_3A) ? 4'd1 : 4'd0;
            end
            else
            begin
                dec.op_len = 2'd2;
                if (r1 == 4'h8)
                begin
                    dec.imm = 4'd4;
                end
                else if ((r1 == 4'h7 && k1 < 4'h4) || op1 == 8'hA4 || op1 == 8'hC2 ||
                         (op1 > 8'hC3 && op1 <= 8'hC6) || op1 == 8'hBA || op1 == 8'hAC)
                begin
                    dec.imm = 4'd1;
                end
                dec.has_modrm = xild_pkg::two_modrm(op1) ||
                                (r1 != 4'h3 && r1 > 4'h0 && r1 < 4'h7) ||
                                op1 >= 8'hD0 || (r1 == 4'h7 && k1 != 4'h7) ||
                                r1 == 4'h9 || r1 == 4'hB ||
                                (r1 == 4'hC && k1 < 4'h8) || (r1 == 4'h0 && k1 < 4'h4);
            end
        end
        else
        begin
            dec.op_len = 2'd1;
            // group 3 takes an immediate only for TEST (reg field 0 or 1)
            if ((r0 == 4'hE && k0 < 4'h8) || (r0 == 4'hB && k0 < 4'h8) || r0 == 4'h7 ||
                (r0 < 4'h4 && (k0 == 4'h4 || k0 == 4'hC)) ||
                (op0 == xild_pkg::OP_GRP3_B && op1[5:4] == 2'b00) ||
                xild_pkg::one_imm8(op0))
            begin
                dec.imm = 4'd1;
            end
            else if (op0 == xild_pkg::OP_RETN_IMM || op0 == xild_pkg::OP_RETF_IMM)
            begin
                dec.imm = 4'd2;
            end
            else if (op0 == xild_pkg::OP_ENTER)
            begin
                dec.imm = 4'd3;
            end
            else if ((r0 < 4'h4 && (k0 == 4'h5 || k0 == 4'hD)) ||
                     (r0 == 4'hB && k0 >= 4'h8) ||
                     (op0 == xild_pkg::OP_GRP3_V && op1[5:4] == 2'b00) ||
                     xild_pkg::one_imm32(op0))
            begin
                dec.imm = full_imm;
            end
            else if (r0 == 4'hA && k0 < 4'h4)
            begin
                dec.imm = rexw ? 4'd8 : (adsz ? 4'd2 : 4'd4);
            end
            else if (op0 == xild_pkg::OP_JMPF || op0 == xild_pkg::OP_CALLF)
            begin
                dec.imm = opsz ? 4'd4 : 4'd6;
            end
            dec.has_modrm = xild_pkg::one_modrm(op0) ||
                            (r0 < 4'h4 && (k0 < 4'h4 || (k0 >= 4'h8 && k0 < 4'hC))) ||
                            r0 == 4'h8 || (r0 == 4'hD && k0 >= 4'h8);
        end
    end

endmodule
`default_nettype wire

### hw/rtl/x86_instruction_length_decoder.sv
// x86 instruction length decoder: top level with four-stage pipeline.
//
// Usage: each beat on the window channel carries 16 instruction bytes, byte 0
// in window_low[7:0]. The decoder returns one beat on the result channel per
// window: the length of the instruction starting at byte 0, or length 0 with
// beyond_window set when the instruction runs past WINDOW_BYTES bytes.
// cfg_we/cfg_wdata write long_mode (1 = bytes 40-4F are REX prefixes); write
// it only while no window is in flight.
// Stages: prefix classification, prefix scan and opcode byte pick, opcode
// decode, ModR/M/SIB/displacement sizing into the output register.
// A window beat passes the stage 1 to 4 registers to result valid; throughput
// is one window per cycle while result.ready is high, with no shared unit.
// Reset empties the pipeline and sets long_mode to 1.
// When the result receiver stalls, each stage holds its beat and ready is
// dropped back stage by stage; nothing is lost or repeated.
`default_nettype none
`include "assert_macros.svh"
module x86_instruction_length_decoder #(
    parameter int WINDOW_BYTES = 16,
    parameter int MAX_PREFIXES = 14
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    xild_in_if.sink          window,
    xild_out_if.source       result
);

    localparam int P_W   = $clog2(MAX_PREFIXES + 1);
    localparam int LEN_W = xild_pkg::LEN_W;
    localparam int WIN_W = xild_pkg::WIN_IN_W;

    logic long_mode_reg;

    // handshake
    logic adv1;
    logic adv2;
    logic adv3;
    logic adv4;

    // stage 1
    logic                    s1_valid_reg;
    logic [WIN_W-1:0]        s1_win_reg;
    logic [MAX_PREFIXES-1:0] s1_pfx_reg;
    logic [MAX_PREFIXES-1:0] s1_opsz_reg;
    logic [MAX_PREFIXES-1:0] s1_adsz_reg;
    logic [MAX_PREFIXES-1:0] s1_rexw_reg;
    logic [MAX_PREFIXES-1:0] s1_pfx_next;
    logic [MAX_PREFIXES-1:0] s1_opsz_next;
    logic [MAX_PREFIXES-1:0] s1_adsz_next;
    logic [MAX_PREFIXES-1:0] s1_rexw_next;

    // stage 2
    logic             s2_valid_reg;
    logic [P_W-1:0]   s2_p_reg;
    logic             s2_opsz_reg;
    logic             s2_adsz_reg;
    logic             s2_rexw_reg;
    xild_pkg::byte_t  s2_b_reg [xild_pkg::PICK_BYTES];
    logic [P_W-1:0]   s2_p_next;
    logic             s2_opsz_next;
    logic             s2_adsz_next;
    logic             s2_rexw_next;
    xild_pkg::byte_t  s2_b_next [xild_pkg::PICK_BYTES];

    // stage 3
    logic              s3_valid_reg;
    xild_pkg::byte_t   s3_m_reg;
    xild_pkg::byte_t   s3_sib_reg;
    logic              s3_adsz_reg;
    logic              s3_modrm_reg;
    logic [3:0]        s3_imm_reg;
    logic [LEN_W-1:0]  s3_base_reg;
    xild_pkg::opdec_t  dec;
    xild_pkg::byte_t   s3_m_next;
    xild_pkg::byte_t   s3_sib_next;
    logic [LEN_W-1:0]  s3_base_next;

    // stage 4
    logic                           s4_valid_reg;
    logic [xild_pkg::OUT_LEN_W-1:0] s4_len_reg;
    logic                           s4_beyond_reg;
    logic [xild_pkg::OUT_LEN_W-1:0] s4_len_next;
    logic                           s4_beyond_next;
    logic [LEN_W-1:0]               full_len;
    logic [3:0]                     extra;

    assign adv4 = !s4_valid_reg || result.ready;
    assign adv3 = !s3_valid_reg || adv4;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;

    assign window.ready        = adv1;
    assign result.valid        = s4_valid_reg;
    assign result.length       = s4_len_reg;
    assign result.beyond_window = s4_beyond_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_mode_reg <= 1'b1;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                long_mode_reg <= cfg_wdata;
            end
            if (adv1)
            begin
                s1_valid_reg <= window.valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (adv4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // stage 1: per-byte prefix classification
    always_comb
    begin
        xild_pkg::byte_t b;
        b = 8'h00;
        for (int i = 0; i < MAX_PREFIXES; i++)
        begin
            b = xild_pkg::byte_at({window.window_high, window.window_low}, 5'(i));
            s1_pfx_next[i]  = xild_pkg::is_legacy(b) ||
                              (long_mode_reg && b[7:4] == xild_pkg::REX_NIB);
            s1_opsz_next[i] = (b == xild_pkg::PFX_OPSZ);
            s1_adsz_next[i] = (b == xild_pkg::PFX_ADSZ);
            s1_rexw_next[i] = long_mode_reg && b[7:4] == xild_pkg::REX_NIB && b[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_win_reg  <= {window.window_high, window.window_low};
            s1_pfx_reg  <= s1_pfx_next;
            s1_opsz_reg <= s1_opsz_next;
            s1_adsz_reg <= s1_adsz_next;
            s1_rexw_reg <= s1_rexw_next;
        end
    end

    // stage 2: prefix run length, flags from consumed prefixes, opcode bytes
    always_comb
    begin
        logic run;
        run          = 1'b1;
        s2_p_next    = P_W'(MAX_PREFIXES);
        s2_opsz_next = 1'b0;
        s2_adsz_next = 1'b0;
        s2_rexw_next = 1'b0;
        for (int i = MAX_PREFIXES - 1; i >= 0; i--)
        begin
            if (!s1_pfx_reg[i])
            begin
                s2_p_next = P_W'(i);
            end
        end
        for (int i = 0; i < MAX_PREFIXES; i++)
        begin
            run          = run & s1_pfx_reg[i];
            s2_opsz_next = s2_opsz_next | (run & s1_opsz_reg[i]);
            s2_adsz_next = s2_adsz_next | (run & s1_adsz_reg[i]);
            s2_rexw_next = s2_rexw_next | (run & s1_rexw_reg[i]);
        end
        for (int k = 0; k < xild_pkg::PICK_BYTES; k++)
        begin
            s2_b_next[k] = xild_pkg::byte_at(s1_win_reg, 5'(s2_p_next) + 5'(k));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_p_reg    <= s2_p_next;
            s2_opsz_reg <= s2_opsz_next;
            s2_adsz_reg <= s2_adsz_next;
            s2_rexw_reg <= s2_rexw_next;
            for (int k = 0; k < xild_pkg::PICK_BYTES; k++)
            begin
                s2_b_reg[k] <= s2_b_next[k];
            end
        end
    end

    // stage 3: opcode decode, pick ModR/M and SIB candidates
    xild_opdec u_opdec (
        .op0  (s2_b_reg[0]),
        .op1  (s2_b_reg[1]),
        .opsz (s2_opsz_reg),
        .adsz (s2_adsz_reg),
        .rexw (s2_rexw_reg),
        .dec  (dec)
    );

    always_comb
    begin
        case (dec.op_len)
            2'd1:
            begin
                s3_m_next   = s2_b_reg[1];
                s3_sib_next = s2_b_reg[2];
            end
            2'd2:
            begin
                s3_m_next   = s2_b_reg[2];
                s3_sib_next = s2_b_reg[3];
            end
            default:
            begin
                s3_m_next   = s2_b_reg[3];
                s3_sib_next = s2_b_reg[4];
            end
        endcase
        // last opcode byte
        s3_base_next = LEN_W'(s2_p_reg) + LEN_W'(dec.op_len) - LEN_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            s3_m_reg     <= s3_m_next;
            s3_sib_reg   <= s3_sib_next;
            s3_adsz_reg  <= s2_adsz_reg;
            s3_modrm_reg <= dec.has_modrm;
            s3_imm_reg   <= dec.imm;
            s3_base_reg  <= s3_base_next;
        end
    end

    // stage 4: ModR/M, SIB and displacement bytes, final length
    always_comb
    begin
        logic [1:0] md;
        logic [2:0] rm;
        logic       sib_f;
        md    = s3_m_reg[7:6];
        rm    = s3_m_reg[2:0];
        sib_f = 1'b0;
        extra = 4'd0;
        if (s3_modrm_reg)
        begin
            extra = 4'd1;
            if (!s3_adsz_reg || md != 2'b00)
            begin
                sib_f = (md != 2'b11) && (rm == 3'd4) && !s3_adsz_reg;
                extra = extra + 4'(sib_f);
                if (md == 2'b01)
                begin
                    extra = extra + 4'd1;
                end
                else if ((md == 2'b00 && rm == 3'd5) || md == 2'b10)
                begin
                    extra = extra + (s3_adsz_reg ? 4'd2 : 4'd4);
                end
                else if (sib_f && s3_sib_reg[2:0] == 3'd5)
                begin
                    extra = extra + (s3_m_reg[6] ? 4'd1 : 4'd4);
                end
            end
            else if (rm == 3'd6)
            begin
                // 16-bit direct address
                extra = extra + 4'd2;
            end
        end
        full_len = s3_base_reg + LEN_W'(1) + LEN_W'(extra) + LEN_W'(s3_imm_reg);
        s4_beyond_next = (full_len > LEN_W'(WINDOW_BYTES));
        s4_len_next    = s4_beyond_next ? '0 : full_len[xild_pkg::OUT_LEN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            s4_len_reg    <= s4_len_next;
            s4_beyond_reg <= s4_beyond_next;
        end
    end

    `XILD_ASSERT(a_pfx_bound, clk, rst_n, s2_valid_reg |-> (s2_p_reg <= P_W'(MAX_PREFIXES)), "prefix run past limit")
    `XILD_ASSERT(a_s2_hold, clk, rst_n, s2_valid_reg && !adv3 |=> s2_valid_reg && $stable(s2_p_reg), "stalled stage 2 beat changed")
    `XILD_ASSERT_IMP(a_beyond_zero, clk, rst_n, s4_valid_reg && s4_beyond_reg, s4_len_reg == '0, "overrun with nonzero length")
    `XILD_ASSERT_IMP(a_len_nonzero, clk, rst_n, s4_valid_reg && !s4_beyond_reg, s4_len_reg != '0, "zero length without overrun")

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for the x86 instruction length decoder.
module tb_top;
    import xild_pkg::*;

    localparam int WIN     = 16;
    localparam int MAX_PFX = 14;

    // Expected-length store with its own copy of the decoder's rules.
    class length_scoreboard;
        bit                   long_mode;
        byte_t                win_bytes [16];
        logic [OUT_LEN_W-1:0] len_q [$];
        logic                 overrun_q [$];
        int unsigned          mismatches;

        function new();
            long_mode  = 1'b1;
            mismatches = 0;
        endfunction

        function int pending();
            return len_q.size();
        endfunction

        function byte_t peek(int idx);
            return (idx < 16) ? win_bytes[idx] : 8'h00;
        endfunction

        // idx is the last byte taken; returns the last byte of ModR/M, SIB and disp
        function int modrm_tail(int idx, bit a16);
            byte_t m;
            byte_t sib_b;
            bit    has_sib;
            has_sib = 1'b0;
            idx++;
            m = peek(idx);
            if (!a16 || m >= 8'h40)
            begin
                if (m < 8'hC0 && m[2:0] == 3'd4 && !a16)
                begin
                    has_sib = 1'b1;
                    idx++;
                end
                sib_b = peek(idx);
                if (m >= 8'h40 && m <= 8'h7F)
                    idx += 1;
                else if ((m <= 8'h3F && m[2:0] == 3'd5) || (m >= 8'h80 && m <= 8'hBF))
                    idx += a16 ? 2 : 4;
                else if (has_sib && sib_b[2:0] == 3'd5)
                    idx += m[6] ? 1 : 4;
            end
            else if ((m & 8'hC7) == 8'h06)
            begin
                idx += 2;   // 16-bit addressing, direct disp16
            end
            return idx;
        endfunction

        function void predict_length(input logic [63:0] lo, input logic [63:0] hi,
                                     output logic [OUT_LEN_W-1:0] len_o, output logic ovr_o);
            int         pos;
            int         imm;
            int         total;
            bit         opsz;
            bit         a16;
            bit         rexw;
            byte_t      c;
            byte_t      nxt;
            logic [3:0] r;
            logic [3:0] k;
            pos  = 0;
            imm  = 0;
            opsz = 1'b0;
            a16  = 1'b0;
            rexw = 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                win_bytes[i]     = lo[8*i +: 8];
                win_bytes[i + 8] = hi[8*i +: 8];
            end
            for (int i = 0; i < MAX_PFX; i++)
            begin
                c = peek(pos);
                if (!(c inside {8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64,
                                8'h65, PFX_OPSZ, PFX_ADSZ} ||
                      (long_mode && c[7:4] == REX_NIB)))
                    break;
                if (c == PFX_OPSZ)
                    opsz = 1'b1;
                else if (c == PFX_ADSZ)
                    a16 = 1'b1;
                else if (c[7:4] == REX_NIB && c[3])
                    rexw = 1'b1;
                pos++;
            end
            c = peek(pos);
            if (c == OP_ESC)
            begin
                pos++;
                c = peek(pos);
                r = c[7:4];
                k = c[3:0];
                if (c == OP_ESC_38 || c == OP_ESC_3A)
                begin
                    if (c == OP_ESC_3A)
                        imm = 1;
                    pos = modrm_tail(pos + 1, a16);
                end
                else
                begin
                    if (r == 4'h8)
                        imm = 4;
                    else if ((r == 4'h7 && k < 4) ||
                             c inside {8'hA4, 8'hC2, 8'hC4, 8'hC5, 8'hC6, 8'hBA, 8'hAC})
                        imm = 1;
                    if (c inside {8'h0D, 8'hA3, 8'hA4, 8'hA5, 8'hAB, 8'hAC, 8'hAD, 8'hAE,
                                  8'hAF} ||
                        (r != 4'h3 && r > 4'h0 && r < 4'h7) || c >= 8'hD0 ||
                        (r == 4'h7 && k != 4'h7) || r == 4'h9 || r == 4'hB ||
                        (r == 4'hC && k < 8) || (r == 4'h0 && k < 4))
                        pos = modrm_tail(pos, a16);
                end
            end
            else
            begin
                r   = c[7:4];
                k   = c[3:0];
                nxt = peek(pos + 1);
                if ((r == 4'hE && k < 8) || (r == 4'hB && k < 8) || r == 4'h7 ||
                    (r < 4 && (k == 4'h4 || k == 4'hC)) ||
                    (c == OP_GRP3_B && (nxt & 8'h30) == 8'h00) ||
                    c inside {8'h6A, 8'h6B, 8'h80, 8'h82, 8'h83, 8'hA8, 8'hC0, 8'hC1,
                              8'hC6, 8'hCD, 8'hD4, 8'hD5, 8'hEB})
                    imm = 1;
                else if (c == OP_RETN_IMM || c == OP_RETF_IMM)
                    imm = 2;
                else if (c == OP_ENTER)
                    imm = 3;
                else if ((r < 4 && (k == 4'h5 || k == 4'hD)) || (r == 4'hB && k >= 8) ||
                         (c == OP_GRP3_V && (nxt & 8'h30) == 8'h00) ||
                         c inside {8'h68, 8'h69, 8'h81, 8'hA9, 8'hC7, 8'hE8, 8'hE9})
                    imm = rexw ? 8 : (opsz ? 2 : 4);
                else if (r == 4'hA && k < 4)
                    imm = rexw ? 8 : (a16 ? 2 : 4);     // moffs
                else if (c == OP_JMPF || c == OP_CALLF)
                    imm = opsz ? 4 : 6;
                if (c inside {8'h62, 8'h63, 8'h69, 8'h6B, 8'hC0, 8'hC1, 8'hC4, 8'hC5,
                              8'hC6, 8'hC7, 8'hD0, 8'hD1, 8'hD2, 8'hD3, OP_GRP3_B,
                              OP_GRP3_V, 8'hFE, 8'hFF} ||
                    (r < 4 && (k < 4 || (k >= 8 && k < 4'hC))) ||
                    r == 4'h8 || (r == 4'hD && k >= 8))
                    pos = modrm_tail(pos, a16);
            end
            total = pos + 1 + imm;
            if (total > WIN)
            begin
                len_o = '0;
                ovr_o = 1'b1;
            end
            else
            begin
                len_o = total[OUT_LEN_W-1:0];
                ovr_o = 1'b0;
            end
        endfunction

        function void note_window(logic [63:0] lo, logic [63:0] hi);
            logic [OUT_LEN_W-1:0] len_e;
            logic                 ovr_e;
            predict_length(lo, hi, len_e, ovr_e);
            len_q.push_back(len_e);
            overrun_q.push_back(ovr_e);
        endfunction

        function void check_result(logic [OUT_LEN_W-1:0] len_a, logic ovr_a);
            logic [OUT_LEN_W-1:0] len_e;
            logic                 ovr_e;
            if (len_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: length=%0d beyond_window=%0b", len_a, ovr_a);
                return;
            end
            len_e = len_q.pop_front();
            ovr_e = overrun_q.pop_front();
            if (len_a !== len_e || ovr_a !== ovr_e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: length exp %0d got %0d, beyond_window exp %0b got %0b",
                             len_e, len_a, ovr_e, ovr_a);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    xild_in_if  win_ch ();
    xild_out_if res_ch ();

    length_scoreboard sb = new();

    int sender_idle_pct = 27;
    int ready_stall_pct = 87;

    byte_t legacy_pfx [11] = '{8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64,
                               8'h65, PFX_OPSZ, PFX_ADSZ};
    byte_t notable_ops [18] = '{OP_GRP3_B, OP_GRP3_V, OP_JMPF, OP_CALLF, OP_RETN_IMM,
                                OP_RETF_IMM, OP_ENTER, 8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hB8,
                                8'h8B, 8'hC7, 8'h69, 8'h81, 8'h05, 8'hE8};

    x86_instruction_length_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .window    (win_ch),
        .result    (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_window(input logic [63:0] lo, input logic [63:0] hi);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            win_ch.valid <= 1'b0;
            @(posedge clk);
        end
        win_ch.valid       <= 1'b1;
        win_ch.window_low  <= lo;
        win_ch.window_high <= hi;
        do
            @(posedge clk);
        while (!win_ch.ready);
        sb.note_window(lo, hi);
    endtask

    // seq lists n bytes, byte 0 leftmost; the rest of the window is pad
    task automatic send_seq(input logic [127:0] seq, input int n, input byte_t pad);
        logic [127:0] w;
        for (int i = 0; i < 16; i++)
            w[8*i +: 8] = (i < n) ? seq[8*(n-1-i) +: 8] : pad;
        send_window(w[63:0], w[127:64]);
    endtask

    // mostly well-formed: prefixes, an opcode of some class, often a loaded ModR/M
    task automatic send_random_window();
        byte_t        b [20];
        int           p;
        logic [127:0] w;
        foreach (b[i])
            b[i] = byte_t'($urandom);
        if ($urandom_range(99) >= 10)
        begin
            p = ($urandom_range(9) == 0) ? $urandom_range(16, 10) : $urandom_range(4, 0);
            for (int i = 0; i < p; i++)
                b[i] = ($urandom_range(2) == 0) ? {REX_NIB, 4'($urandom)}
                                                : legacy_pfx[$urandom_range(10)];
            case ($urandom_range(3))
                0: p += 1;
                1:
                begin
                    b[p] = OP_ESC;
                    p += 2;
                end
                2:
                begin
                    b[p]     = OP_ESC;
                    b[p + 1] = $urandom_range(1) ? OP_ESC_38 : OP_ESC_3A;
                    p += 3;
                end
                default:
                begin
                    b[p] = notable_ops[$urandom_range(17)];
                    p += 1;
                end
            endcase
            if (p < 19 && $urandom_range(99) < 40)
            begin
                b[p] = {2'($urandom), 3'($urandom), 3'($urandom_range(6, 4))};
                if ($urandom_range(1))
                    b[p + 1][2:0] = 3'd5;
            end
        end
        for (int i = 0; i < 16; i++)
            w[8*i +: 8] = b[i];
        send_window(w[63:0], w[127:64]);
    endtask

    task automatic drain();
        win_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_long_mode(input bit v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we       <= 1'b0;
        sb.long_mode = v;
    endtask

    // result side: check each beat, then pick ready for the next cycle
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.length, res_ch.beyond_window);
            res_ch.ready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= 1'b0;
        win_ch.valid       <= 1'b0;
        win_ch.window_low  <= '0;
        win_ch.window_high <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, long mode from reset
        send_seq(8'h90, 1, 8'h00);
        send_seq('0, 0, 8'h00);
        send_seq('0, 0, 8'hFF);
        send_seq(16'h66_05, 2, 8'h11);              // operand size: imm16
        send_seq(16'h48_B8, 2, 8'h5A);              // REX.W: imm64
        send_seq(24'h67_8B_06, 3, 8'hA5);           // 16-bit addressing, direct disp16
        send_seq(24'h67_8B_46, 3, 8'h3C);
        send_seq(24'h8B_04_25, 3, 8'h00);           // SIB base 101 under mod 00
        send_seq(24'h8B_44_25, 3, 8'h00);
        send_seq(16'hF6_C0, 2, 8'h7E);              // group 3 test carries an immediate
        send_seq(16'hF7_C0, 2, 8'h81);
        send_seq(16'hF7_D8, 2, 8'h81);
        send_seq(8'hEA, 1, 8'h00);
        send_seq(16'h66_EA, 2, 8'h00);
        send_seq(8'h9A, 1, 8'hC3);
        send_seq(8'hC2, 1, 8'h00);
        send_seq(8'hCA, 1, 8'h00);
        send_seq(8'hC8, 1, 8'h00);
        send_seq(16'h67_A1, 2, 8'h00);              // moffs
        send_seq(16'h48_A1, 2, 8'h00);
        send_seq(32'h0F_38_00_C0, 4, 8'h00);
        send_seq(32'h0F_3A_0F_C0, 4, 8'h00);
        send_seq(16'h0F_80, 2, 8'hFE);
        send_seq({{14{8'hF3}}, 8'h90}, 15, 8'h00);  // prefix limit reached
        send_seq({{14{8'h40}}, 16'h0F_38}, 16, 8'h00);  // runs past the window
        drain();
        set_long_mode(1'b0);
        send_seq(16'h48_B8, 2, 8'h00);              // 48 is an opcode here
        send_seq({{14{8'h4F}}, 8'h90}, 15, 8'h00);

        for (int ph = 0; ph < 6; ph++)
        begin
            sender_idle_pct = (ph < 2) ? 27 : ((ph < 4) ? 87 : 0);
            ready_stall_pct = (ph < 2) ? 87 : ((ph < 4) ? 27 : 0);
            drain();
            set_long_mode(ph % 2 == 0);
            for (int n = 0; n < 330; n++)
            begin
                if (ph == 0 && n == 150)
                    drain();
                send_random_window();
            end
        end
        drain();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
